### rtl/ualu_pkg.sv
// shared opcodes and constants for the unsigned integer alu
package ualu_pkg;

   typedef logic [2:0] cmd_type;

   localparam cmd_type CMD_ADD = 3'd0;
   localparam cmd_type CMD_SUB = 3'd1;
   localparam cmd_type CMD_MUL = 3'd2;
   localparam cmd_type CMD_DIV = 3'd3;
   localparam cmd_type CMD_MOD = 3'd4;
   localparam cmd_type CMD_POW = 3'd5;

   // multiplier bits retired per multiply cycle
   localparam int MUL_DIGIT = 4;

endpackage

### rtl/ualu_mul.sv
// iterative digit-serial multiplier giving the low WIDTH bits of a product
module ualu_mul #(
   parameter int WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             go,
   input  logic [WIDTH-1:0] mcand,
   input  logic [WIDTH-1:0] mplier,
   output logic             done,
   output logic [WIDTH-1:0] product
);

   localparam int DIG   = ualu_pkg::MUL_DIGIT;
   localparam int STEPS = (WIDTH + DIG - 1) / DIG;
   localparam int PAD_W = STEPS * DIG;
   localparam int CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;

   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [WIDTH-1:0]       acc_ff, acc_in;
   logic [WIDTH-1:0]       mcand_ff, mcand_in;
   logic [PAD_W-1:0]       mplier_ff, mplier_in;
   logic [DIG-1:0]         digit;
   logic [WIDTH+DIG-1:0]   part;

   assign digit = mplier_ff[PAD_W-1 -: DIG];
   assign part  = {{DIG{1'b0}}, mcand_ff} * {{WIDTH{1'b0}}, digit};

   always_comb begin
      busy_in   = busy_ff;
      done_in   = 1'b0;
      count_in  = count_ff;
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      if (go) begin
         busy_in   = 1'b1;
         count_in  = '0;
         acc_in    = '0;
         mcand_in  = mcand;
         mplier_in = PAD_W'(mplier);
      end else if (busy_ff) begin
         // horner step from the most significant digit
         acc_in    = (acc_ff << DIG) + part[WIDTH-1:0];
         mplier_in = mplier_ff << DIG;
         count_in  = count_ff + 1'b1;
         if (count_ff == CNT_W'(STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

### rtl/ualu_div.sv
// radix-2 restoring divider, one quotient bit per cycle
module ualu_div #(
   parameter int WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             go,
   input  logic [WIDTH-1:0] dividend,
   input  logic [WIDTH-1:0] divisor,
   output logic             done,
   output logic [WIDTH-1:0] quotient,
   output logic [WIDTH-1:0] rem
);

   localparam int CNT_W = $clog2(WIDTH);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [WIDTH-1:0]    rem_ff, rem_in;
   logic [WIDTH-1:0]    quo_ff, quo_in;
   logic [WIDTH-1:0]    dsr_ff, dsr_in;
   logic [WIDTH:0]      shifted;
   logic [WIDTH:0]      trial;

   assign shifted = {rem_ff, quo_ff[WIDTH-1]};
   assign trial   = shifted - {1'b0, dsr_ff};

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      dsr_in   = dsr_ff;
      if (go) begin
         busy_in  = 1'b1;
         count_in = '0;
         rem_in   = '0;
         quo_in   = dividend;
         dsr_in   = divisor;
      end else if (busy_ff) begin
         if (trial[WIDTH]) begin
            rem_in = shifted[WIDTH-1:0];
            quo_in = {quo_ff[WIDTH-2:0], 1'b0};
         end else begin
            rem_in = trial[WIDTH-1:0];
            quo_in = {quo_ff[WIDTH-2:0], 1'b1};
         end
         count_in = count_ff + 1'b1;
         if (count_ff == CNT_W'(WIDTH - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
   assign rem      = rem_ff;

endmodule

### rtl/unsigned_int_alu_with_divide_power_core.sv
// top level: unsigned integer alu with sequencer, shared multiplier and divider
//
// A transaction is taken at a rising edge with start high and busy low; req_cmd
// selects add, absolute difference, multiply, divide, modulo or power on
// req_operand_a and req_operand_b. Each transaction gives one response, shown
// for exactly one cycle with rsp_valid high; the receiver cannot stall it.
// Add, absolute difference, a zero divisor and an unused opcode are answered
// without the multiplier or divider; busy stays low so a new transaction may
// follow at once. Multiply uses the multiplier, divide and modulo the divider,
// and power runs one multiply per exponent bit up to the highest one set plus
// one more per set bit below the highest.
// The multiplier retires four bits per cycle and the divider one quotient bit
// per cycle; both are shared and the sequencer runs one transaction at a time.
// Busy is high from the accepting edge of a multi-cycle transaction until its
// response cycle. Synchronous reset returns the sequencer to idle and drops
// rsp_valid; a transaction in flight is discarded.
module unsigned_int_alu_with_divide_power_core #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  ualu_pkg::cmd_type     req_cmd,
   input  logic [DATA_WIDTH-1:0] req_operand_a,
   input  logic [DATA_WIDTH-1:0] req_operand_b,
   output logic                  rsp_valid,
   output logic [DATA_WIDTH-1:0] rsp_result,
   output logic [DATA_WIDTH-1:0] rsp_remainder,
   output logic                  rsp_divide_by_zero,
   output logic                  rsp_a_below_b
);

   localparam int W = DATA_WIDTH;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV,
      ST_POW_STEP,
      ST_POW_ACC,
      ST_POW_SQ
   } state_type;

   state_type          state_ff, state_in;
   ualu_pkg::cmd_type  op_ff, op_in;
   logic [W-1:0]       acc_ff, acc_in;
   logic [W-1:0]       sq_ff, sq_in;
   logic [W-1:0]       exp_ff, exp_in;
   logic               mul_go_ff, mul_go_in;
   logic [W-1:0]       mul_x_ff, mul_x_in;
   logic [W-1:0]       mul_y_ff, mul_y_in;
   logic               div_go_ff, div_go_in;
   logic [W-1:0]       div_n_ff, div_n_in;
   logic [W-1:0]       div_d_ff, div_d_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [W-1:0]       rsp_result_ff, rsp_result_in;
   logic [W-1:0]       rsp_remainder_ff, rsp_remainder_in;
   logic               rsp_dz_ff, rsp_dz_in;
   logic               rsp_below_ff, rsp_below_in;

   logic               mul_done;
   logic [W-1:0]       mul_product;
   logic               div_done;
   logic [W-1:0]       div_quotient;
   logic [W-1:0]       div_rem;

   ualu_mul #(.WIDTH(W)) u_mul (
      .clock   (clock),
      .reset   (reset),
      .go      (mul_go_ff),
      .mcand   (mul_x_ff),
      .mplier  (mul_y_ff),
      .done    (mul_done),
      .product (mul_product)
   );

   ualu_div #(.WIDTH(W)) u_div (
      .clock    (clock),
      .reset    (reset),
      .go       (div_go_ff),
      .dividend (div_n_ff),
      .divisor  (div_d_ff),
      .done     (div_done),
      .quotient (div_quotient),
      .rem      (div_rem)
   );

   always_comb begin
      state_in         = state_ff;
      op_in            = op_ff;
      acc_in           = acc_ff;
      sq_in            = sq_ff;
      exp_in           = exp_ff;
      mul_go_in        = 1'b0;
      mul_x_in         = mul_x_ff;
      mul_y_in         = mul_y_ff;
      div_go_in        = 1'b0;
      div_n_in         = div_n_ff;
      div_d_in         = div_d_ff;
      rsp_valid_in     = 1'b0;
      rsp_result_in    = rsp_result_ff;
      rsp_remainder_in = rsp_remainder_ff;
      rsp_dz_in        = rsp_dz_ff;
      rsp_below_in     = rsp_below_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               op_in            = req_cmd;
               rsp_result_in    = '0;
               rsp_remainder_in = '0;
               rsp_dz_in        = 1'b0;
               rsp_below_in     = 1'b0;
               case (req_cmd)
                  ualu_pkg::CMD_ADD: begin
                     rsp_valid_in  = 1'b1;
                     rsp_result_in = req_operand_a + req_operand_b;
                  end
                  ualu_pkg::CMD_SUB: begin
                     rsp_valid_in = 1'b1;
                     if (req_operand_a < req_operand_b) begin
                        rsp_below_in  = 1'b1;
                        rsp_result_in = req_operand_b - req_operand_a;
                     end else begin
                        rsp_result_in = req_operand_a - req_operand_b;
                     end
                  end
                  ualu_pkg::CMD_MUL: begin
                     mul_go_in = 1'b1;
                     mul_x_in  = req_operand_a;
                     mul_y_in  = req_operand_b;
                     state_in  = ST_MUL;
                  end
                  ualu_pkg::CMD_DIV, ualu_pkg::CMD_MOD: begin
                     if (req_operand_b == '0) begin
                        rsp_valid_in = 1'b1;
                        rsp_dz_in    = 1'b1;
                     end else begin
                        div_go_in = 1'b1;
                        div_n_in  = req_operand_a;
                        div_d_in  = req_operand_b;
                        state_in  = ST_DIV;
                     end
                  end
                  ualu_pkg::CMD_POW: begin
                     acc_in   = W'(1);
                     sq_in    = req_operand_a;
                     exp_in   = req_operand_b;
                     state_in = ST_POW_STEP;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_MUL: begin
            if (mul_done) begin
               rsp_valid_in  = 1'b1;
               rsp_result_in = mul_product;
               state_in      = ST_IDLE;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               rsp_valid_in = 1'b1;
               if (op_ff == ualu_pkg::CMD_MOD) begin
                  rsp_result_in = div_rem;
               end else begin
                  rsp_result_in    = div_quotient;
                  rsp_remainder_in = div_rem;
               end
               state_in = ST_IDLE;
            end
         end
         ST_POW_STEP: begin
            if (exp_ff == '0) begin
               rsp_valid_in  = 1'b1;
               rsp_result_in = acc_ff;
               state_in      = ST_IDLE;
            end else if (exp_ff[0]) begin
               mul_go_in = 1'b1;
               mul_x_in  = acc_ff;
               mul_y_in  = sq_ff;
               state_in  = ST_POW_ACC;
            end else begin
               mul_go_in = 1'b1;
               mul_x_in  = sq_ff;
               mul_y_in  = sq_ff;
               state_in  = ST_POW_SQ;
            end
         end
         ST_POW_ACC: begin
            if (mul_done) begin
               acc_in = mul_product;
               // no higher exponent bits left: skip the last squaring
               if (exp_ff[W-1:1] == '0) begin
                  exp_in   = '0;
                  state_in = ST_POW_STEP;
               end else begin
                  mul_go_in = 1'b1;
                  mul_x_in  = sq_ff;
                  mul_y_in  = sq_ff;
                  state_in  = ST_POW_SQ;
               end
            end
         end
         ST_POW_SQ: begin
            if (mul_done) begin
               sq_in    = mul_product;
               exp_in   = exp_ff >> 1;
               state_in = ST_POW_STEP;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mul_go_ff    <= 1'b0;
         div_go_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mul_go_ff    <= mul_go_in;
         div_go_ff    <= div_go_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff            <= op_in;
      acc_ff           <= acc_in;
      sq_ff            <= sq_in;
      exp_ff           <= exp_in;
      mul_x_ff         <= mul_x_in;
      mul_y_ff         <= mul_y_in;
      div_n_ff         <= div_n_in;
      div_d_ff         <= div_d_in;
      rsp_result_ff    <= rsp_result_in;
      rsp_remainder_ff <= rsp_remainder_in;
      rsp_dz_ff        <= rsp_dz_in;
      rsp_below_ff     <= rsp_below_in;
   end

   assign busy               = (state_ff != ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result         = rsp_result_ff;
   assign rsp_remainder      = rsp_remainder_ff;
   assign rsp_divide_by_zero = rsp_dz_ff;
   assign rsp_a_below_b      = rsp_below_ff;

`ifndef SYNTH
   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_dz_ff && rsp_below_ff))
      else $error("both response flags set");

   a_dz_zero_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_dz_ff) |-> (rsp_result_ff == '0 && rsp_remainder_ff == '0))
      else $error("zero divisor response carries data");

   a_mul_done_state: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> (state_ff == ST_MUL || state_ff == ST_POW_ACC || state_ff == ST_POW_SQ))
      else $error("multiplier finished outside a multiply state");

   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIV))
      else $error("divider finished outside the divide state");
`endif

endmodule

### test/tb_unsigned_int_alu_with_divide_power_core.sv
// self-checking testbench for the unsigned integer alu with divide and power
`timescale 1ns / 100ps

module tb_unsigned_int_alu_with_divide_power_core;

   localparam int W = 32;
   localparam int RESET_CYCLES = 8;
   localparam int RANDOM_ITEMS = 650;
   localparam int STALL_LIMIT = 4000;
   localparam int DRAIN_CYCLES = 40;
   localparam int NUM_DIRECTED = 24;

   localparam ualu_pkg::cmd_type CMD_UNUSED_6 = 3'd6;
   localparam ualu_pkg::cmd_type CMD_UNUSED_7 = 3'd7;
   localparam ualu_pkg::cmd_type VALID_CMDS [6] = '{ualu_pkg::CMD_ADD,
      ualu_pkg::CMD_SUB, ualu_pkg::CMD_MUL, ualu_pkg::CMD_DIV, ualu_pkg::CMD_MOD,
      ualu_pkg::CMD_POW};
   localparam int IDLE_PCT [3] = '{0, 50, 16};

   typedef logic [W-1:0] word_type;

   typedef struct packed {
      word_type result;
      word_type remainder;
      logic     div_zero;
      logic     a_below;
   } alu_result_type;

   typedef struct packed {
      ualu_pkg::cmd_type cmd;
      word_type          a;
      word_type          b;
      logic              known;
      alu_result_type    want;
   } directed_op_type;

   localparam word_type MAXW = '1;
   localparam alu_result_type ZERO_RES = '0;
   localparam alu_result_type DZ_RES = '{result: '0, remainder: '0, div_zero: 1'b1,
                                         a_below: 1'b0};

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   ualu_pkg::cmd_type req_cmd;
   word_type          req_operand_a;
   word_type          req_operand_b;
   logic              rsp_valid;
   word_type          rsp_result;
   word_type          rsp_remainder;
   logic              rsp_divide_by_zero;
   logic              rsp_a_below_b;

   alu_result_type  pending_results [$];
   directed_op_type directed_ops [NUM_DIRECTED];
   int              error_count;
   int              quiet_cycles;
   int              idle_pct;

   unsigned_int_alu_with_divide_power_core #(.DATA_WIDTH(W)) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_cmd(req_cmd),
      .req_operand_a(req_operand_a),
      .req_operand_b(req_operand_b),
      .rsp_valid(rsp_valid),
      .rsp_result(rsp_result),
      .rsp_remainder(rsp_remainder),
      .rsp_divide_by_zero(rsp_divide_by_zero),
      .rsp_a_below_b(rsp_a_below_b)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   function automatic alu_result_type alu_compute(ualu_pkg::cmd_type c, word_type a,
                                                  word_type b);
      alu_result_type r;
      word_type acc;
      word_type sq;
      r = '0;
      case (c)
         ualu_pkg::CMD_ADD: r.result = a + b;
         ualu_pkg::CMD_SUB: begin
            if (a < b) begin
               r.a_below = 1'b1;
               r.result = b - a;
            end else begin
               r.result = a - b;
            end
         end
         ualu_pkg::CMD_MUL: r.result = a * b;
         ualu_pkg::CMD_DIV: begin
            if (b == '0) begin
               r.div_zero = 1'b1;
            end else begin
               r.result = a / b;
               r.remainder = a % b;
            end
         end
         ualu_pkg::CMD_MOD: begin
            if (b == '0) r.div_zero = 1'b1;
            else r.result = a % b;
         end
         ualu_pkg::CMD_POW: begin
            acc = 1;
            sq = a;
            for (int i = 0; i < W; i++) begin
               if (b[i]) acc = acc * sq;
               sq = sq * sq;
            end
            r.result = acc;
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic word_type pick_operand();
      case ($urandom_range(9))
         0: return '0;
         1: return 1;
         2: return MAXW;
         3: return 32'h8000_0000 | word_type'($urandom_range(15));
         4, 5: return word_type'($urandom_range(255));
         default: return word_type'($urandom);
      endcase
   endfunction

   task automatic report_mismatch(input string field, input word_type got,
                                  input word_type want);
      $display("mismatch %s: got %h expected %h at %0t", field, got, want, $realtime);
      error_count++;
   endtask

   // drives one transaction and holds it until it is taken
   task automatic send_op(input ualu_pkg::cmd_type c, input word_type a, input word_type b,
                          input logic known, input alu_result_type want);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_cmd <= c;
      req_operand_a <= a;
      req_operand_b <= b;
      do @(posedge clock); while (busy);
      pending_results.push_back(known ? want : alu_compute(c, a, b));
   endtask

   task automatic send_random();
      ualu_pkg::cmd_type c;
      word_type a;
      word_type b;
      if ($urandom_range(99) < 3) c = $urandom_range(1) ? CMD_UNUSED_6 : CMD_UNUSED_7;
      else c = VALID_CMDS[$urandom_range(5)];
      a = pick_operand();
      b = pick_operand();
      if (c == ualu_pkg::CMD_POW && $urandom_range(9) < 8) b = word_type'($urandom_range(40));
      send_op(c, a, b, 1'b0, ZERO_RES);
   endtask

   // response checking and watchdog
   always @(posedge clock) begin
      alu_result_type exp_res;
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected response", rsp_result, '0);
         end else begin
            exp_res = pending_results.pop_front();
            if (rsp_result !== exp_res.result)
               report_mismatch("result", rsp_result, exp_res.result);
            if (rsp_remainder !== exp_res.remainder)
               report_mismatch("remainder", rsp_remainder, exp_res.remainder);
            if (rsp_divide_by_zero !== exp_res.div_zero)
               report_mismatch("divide_by_zero", rsp_divide_by_zero, exp_res.div_zero);
            if (rsp_a_below_b !== exp_res.a_below)
               report_mismatch("a_below_b", rsp_a_below_b, exp_res.a_below);
         end
      end
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb_unsigned_int_alu_with_divide_power_core failed");
            $finish;
         end
      end
   end

   initial begin
      error_count = 0;
      quiet_cycles = 0;
      idle_pct = 0;
      reset = 1'b1;
      start = 1'b0;
      req_cmd = ualu_pkg::CMD_ADD;
      req_operand_a = '0;
      req_operand_b = '0;

      directed_ops = '{
         '{ualu_pkg::CMD_ADD, 32'd0, 32'd0, 1'b1, ZERO_RES},
         '{ualu_pkg::CMD_ADD, MAXW, 32'd1, 1'b1, ZERO_RES},
         '{ualu_pkg::CMD_ADD, MAXW, MAXW, 1'b0, ZERO_RES},
         '{ualu_pkg::CMD_SUB, 32'd0, MAXW, 1'b1, '{MAXW, 32'd0, 1'b0, 1'b1}},
         '{ualu_pkg::CMD_SUB, MAXW, 32'd0, 1'b1, '{MAXW, 32'd0, 1'b0, 1'b0}},
         '{ualu_pkg::CMD_SUB, 32'd7, 32'd7, 1'b1, ZERO_RES},
         '{ualu_pkg::CMD_SUB, 32'd5, 32'd9, 1'b0, ZERO_RES},
         '{ualu_pkg::CMD_MUL, MAXW, MAXW, 1'b0, ZERO_RES},
         '{ualu_pkg::CMD_MUL, 32'h0001_0000, 32'h0001_0000, 1'b1, ZERO_RES},
         '{ualu_pkg::CMD_DIV, 32'd100, 32'd7, 1'b0, ZERO_RES},
         '{ualu_pkg::CMD_DIV, MAXW, 32'd1, 1'b1, '{MAXW, 32'd0, 1'b0, 1'b0}},
         '{ualu_pkg::CMD_DIV, 32'd5, 32'd0, 1'b1, DZ_RES},
         '{ualu_pkg::CMD_DIV, 32'd0, MAXW, 1'b1, ZERO_RES},
         '{ualu_pkg::CMD_MOD, 32'd100, 32'd7, 1'b0, ZERO_RES},
         '{ualu_pkg::CMD_MOD, 32'd9, 32'd0, 1'b1, DZ_RES},
         '{ualu_pkg::CMD_MOD, MAXW, MAXW, 1'b1, ZERO_RES},
         '{ualu_pkg::CMD_POW, 32'd0, 32'd0, 1'b1, '{32'd1, 32'd0, 1'b0, 1'b0}},
         '{ualu_pkg::CMD_POW, MAXW, 32'd0, 1'b1, '{32'd1, 32'd0, 1'b0, 1'b0}},
         '{ualu_pkg::CMD_POW, 32'd3, 32'd5, 1'b0, ZERO_RES},
         '{ualu_pkg::CMD_POW, 32'd2, 32'd32, 1'b1, ZERO_RES},
         '{ualu_pkg::CMD_POW, MAXW, MAXW, 1'b0, ZERO_RES},
         '{ualu_pkg::CMD_POW, 32'h1234_5678, 32'h8000_0001, 1'b0, ZERO_RES},
         '{CMD_UNUSED_6, MAXW, MAXW, 1'b1, ZERO_RES},
         '{CMD_UNUSED_7, MAXW, 32'd0, 1'b1, ZERO_RES}
      };

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_ops[i])
         send_op(directed_ops[i].cmd, directed_ops[i].a, directed_ops[i].b,
                 directed_ops[i].known, directed_ops[i].want);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         idle_pct = IDLE_PCT[n * 3 / RANDOM_ITEMS];
         send_random();
      end

      start <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0)
         $display("tb_unsigned_int_alu_with_divide_power_core passed");
      else
         $display("tb_unsigned_int_alu_with_divide_power_core failed");
      $finish;
   end

endmodule

### unsigned_int_alu_with_divide_power_core.f
rtl/ualu_pkg.sv
rtl/ualu_mul.sv
rtl/ualu_div.sv
rtl/unsigned_int_alu_with_divide_power_core.sv
test/tb_unsigned_int_alu_with_divide_power_core.sv
